>>> rtl/core/uld_pkg.sv
// Shared types and constants of the USB port load detector.
`default_nettype none

package uld_pkg;

	localparam int unsigned CNT_BITS      = 8;
	localparam int unsigned WAKE_BITS     = 7;
	localparam int unsigned ADC_MAX_BITS  = 16;
	localparam int unsigned CFG_ADC_BITS  = 12;
	localparam int unsigned APB_ADDR_BITS = 4;
	localparam int unsigned APB_DATA_BITS = 32;

	localparam logic [WAKE_BITS-1:0] WAKE_LIMIT     = 7'd100;
	localparam logic [CNT_BITS-1:0]  BATT_LOW_BLOCK = 8'd30;
	localparam logic [CNT_BITS-1:0]  CNT_MAX        = 8'd255;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_IN   = 2'd1,
		EV_OUT  = 2'd2
	} uld_event_t;

	typedef enum logic [1:0] {
		REG_INSERT_CHECK = 2'd0,
		REG_LOW_TICKS    = 2'd1,
		REG_PROHIBIT     = 2'd2,
		REG_LOW_LIMIT    = 2'd3
	} uld_reg_t;

	typedef struct packed {
		logic                 level_seen;
		logic                 rising_latch;
		logic                 load_flag;
		logic [CNT_BITS-1:0]  present_count;
		logic [CNT_BITS-1:0]  absent_count;
		logic [CNT_BITS-1:0]  prohibit_count;
		logic [WAKE_BITS-1:0] wake_count;
	} uld_state_t;

	// period settings; the current limit travels separately since its width varies
	typedef struct packed {
		logic [CNT_BITS-1:0] insert_check_ticks;
		logic [CNT_BITS-1:0] low_current_ticks;
		logic [CNT_BITS-1:0] prohibit_ticks;
	} uld_cfg_t;

	typedef struct packed {
		logic                kind;
		logic                port_sense;
		logic                wake_request;
		logic                discharging;
		logic                typec_charging;
		logic                second_port_charging;
		logic [CNT_BITS-1:0] battery_low_count;
		logic                temp_ok;
	} uld_flags_t;

endpackage

`default_nettype wire

>>> rtl/core/uld_if.sv
// Valid/ready channel interfaces for detector items and results.
`default_nettype none

interface uld_item_if #(
	parameter int unsigned ADC_BITS = 12
) ();
	logic                valid;
	logic                ready;
	logic                kind;
	logic                port_sense;
	logic                wake_request;
	logic [ADC_BITS-1:0] load_current;
	logic                discharging;
	logic                typec_charging;
	logic                second_port_charging;
	logic [7:0]          battery_low_count;
	logic                temp_ok;

	modport source (
		output valid, kind, port_sense, wake_request, load_current, discharging,
		       typec_charging, second_port_charging, battery_low_count, temp_ok,
		input  ready
	);
	modport sink (
		input  valid, kind, port_sense, wake_request, load_current, discharging,
		       typec_charging, second_port_charging, battery_low_count, temp_ok,
		output ready
	);
endinterface

interface uld_result_if ();
	logic       valid;
	logic       ready;
	logic [1:0] event_res;
	logic       load_present;
	logic       prohibit_active;

	modport source (
		output valid, event_res, load_present, prohibit_active,
		input  ready
	);
	modport sink (
		input  valid, event_res, load_present, prohibit_active,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/core/uld_step.sv
// Next-state and event logic for one detector transaction.
`default_nettype none

module uld_step #(
	parameter int unsigned ADC_BITS = 12
) (
	input  uld_pkg::uld_state_t  st,
	input  uld_pkg::uld_cfg_t    cfg,
	input  logic [ADC_BITS-1:0]  low_current_limit,
	input  uld_pkg::uld_flags_t  flags,
	input  logic [ADC_BITS-1:0]  load_current,
	output uld_pkg::uld_state_t  st_next,
	output uld_pkg::uld_event_t  ev
);
	import uld_pkg::*;

	logic [WAKE_BITS-1:0] wake_a;
	logic [WAKE_BITS-1:0] wake_b;
	logic                 wake_done;
	logic                 gated;

	always_comb begin
		st_next   = st;
		ev        = EV_NONE;
		wake_a    = st.wake_count;
		wake_b    = st.wake_count;
		wake_done = 1'b0;
		gated     = 1'b0;

		if (flags.kind) begin
			// forced removal touches nothing else
			st_next.load_flag      = 1'b0;
			st_next.absent_count   = '0;
			st_next.prohibit_count = cfg.prohibit_ticks;
			ev                     = EV_OUT;
		end else begin
			if (flags.wake_request && st.wake_count == '0)
				wake_a = WAKE_BITS'(1);
			else
				wake_a = st.wake_count;
			if (wake_a != '0) begin
				wake_b = wake_a + WAKE_BITS'(1);
				if (wake_b >= WAKE_LIMIT) begin
					wake_b    = '0;
					wake_done = 1'b1;
				end
			end else begin
				wake_b = wake_a;
			end
			st_next.wake_count = wake_b;
			if (wake_done)
				st_next.level_seen = 1'b0;

			if (flags.port_sense) begin
				if (!st_next.level_seen) begin
					st_next.level_seen   = 1'b1;
					st_next.rising_latch = 1'b1;
				end
			end else begin
				st_next.level_seen = 1'b0;
			end

			if (st.prohibit_count != '0)
				st_next.prohibit_count = st.prohibit_count - CNT_BITS'(1);

			gated = (st_next.prohibit_count != '0) || flags.typec_charging
				|| flags.second_port_charging
				|| (flags.battery_low_count >= BATT_LOW_BLOCK) || !flags.temp_ok;

			if (gated) begin
				st_next.rising_latch = 1'b0;
			end else begin
				if (!st.load_flag) begin
					st_next.absent_count = '0;
					if (st.present_count != CNT_MAX)
						st_next.present_count = st.present_count + CNT_BITS'(1);
					// compare uses the count before the increment
					if (st.present_count > cfg.insert_check_ticks) begin
						st_next.present_count = '0;
						if (st_next.rising_latch) begin
							st_next.rising_latch = 1'b0;
							st_next.load_flag    = 1'b1;
							ev                   = EV_IN;
						end
					end
				end else begin
					st_next.present_count = '0;
				end

				if (!flags.discharging && st_next.load_flag) begin
					if (load_current < low_current_limit) begin
						if (st_next.absent_count != CNT_MAX)
							st_next.absent_count = st_next.absent_count + CNT_BITS'(1);
						if (st.load_flag && st.absent_count > cfg.low_current_ticks) begin
							st_next.load_flag      = 1'b0;
							st_next.absent_count   = '0;
							st_next.prohibit_count = cfg.prohibit_ticks;
							ev                     = EV_OUT;
						end
					end else begin
						st_next.absent_count = '0;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/usb_port_load_detector.sv
// Top level of the USB port load detector: APB registers, input and result stages.
// An accepted transaction is registered in the input stage, and its result in the result register.
// Throughput: one transaction per cycle while results are taken; the state update sets the rate.
// A waiting result holds the input stage, so input stalls once that stage is full.
// Reset (arst_n low, asynchronous): state counters and flags clear, registers take
// their defaults (20, 100, 200, 70), both stages empty.
`default_nettype none

module usb_port_load_detector #(
	parameter int unsigned ADC_BITS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [uld_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [uld_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [uld_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                               pready,
	uld_item_if.sink                           item,
	uld_result_if.source                       result
);
	import uld_pkg::*;

	uld_cfg_t            cfg_q;
	logic [ADC_BITS-1:0] limit_q;
	uld_state_t          state_q;
	uld_state_t          state_next;
	uld_event_t          ev_next;

	logic                s1_valid_s1;
	uld_flags_t          flags_s1;
	logic [ADC_BITS-1:0] current_s1;

	logic                res_valid_q;
	logic [1:0]          res_event_q;
	logic                res_load_q;
	logic                res_prohibit_q;

	logic                advance;
	logic                cfg_write;
	uld_reg_t            reg_sel;
	logic [ADC_MAX_BITS-1:0] limit_wide;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign reg_sel   = uld_reg_t'(paddr[3:2]);
	assign limit_wide = ADC_MAX_BITS'(pwdata[CFG_ADC_BITS-1:0]);

	always_comb begin
		case (reg_sel)
			REG_INSERT_CHECK: prdata = APB_DATA_BITS'(cfg_q.insert_check_ticks);
			REG_LOW_TICKS:    prdata = APB_DATA_BITS'(cfg_q.low_current_ticks);
			REG_PROHIBIT:     prdata = APB_DATA_BITS'(cfg_q.prohibit_ticks);
			REG_LOW_LIMIT:    prdata = APB_DATA_BITS'(limit_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.insert_check_ticks <= 8'd20;
			cfg_q.low_current_ticks  <= 8'd100;
			cfg_q.prohibit_ticks     <= 8'd200;
			limit_q                  <= ADC_BITS'(70);
		end else if (cfg_write) begin
			case (reg_sel)
				REG_INSERT_CHECK: cfg_q.insert_check_ticks <= pwdata[CNT_BITS-1:0];
				REG_LOW_TICKS:    cfg_q.low_current_ticks  <= pwdata[CNT_BITS-1:0];
				REG_PROHIBIT:     cfg_q.prohibit_ticks     <= pwdata[CNT_BITS-1:0];
				REG_LOW_LIMIT:    limit_q                  <= limit_wide[ADC_BITS-1:0];
				default:          ;
			endcase
		end
	end

	// the stage moves whenever the result slot is empty or being drained
	assign advance    = !res_valid_q || result.ready;
	assign item.ready = !s1_valid_s1 || advance;

	uld_step #(
		.ADC_BITS(ADC_BITS)
	) u_step (
		.st                (state_q),
		.cfg               (cfg_q),
		.low_current_limit (limit_q),
		.flags             (flags_s1),
		.load_current      (current_s1),
		.st_next           (state_next),
		.ev                (ev_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (item.ready)
				s1_valid_s1 <= item.valid;
			if (advance) begin
				res_valid_q <= s1_valid_s1;
				if (s1_valid_s1)
					state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			flags_s1.kind                 <= item.kind;
			flags_s1.port_sense           <= item.port_sense;
			flags_s1.wake_request         <= item.wake_request;
			flags_s1.discharging          <= item.discharging;
			flags_s1.typec_charging       <= item.typec_charging;
			flags_s1.second_port_charging <= item.second_port_charging;
			flags_s1.battery_low_count    <= item.battery_low_count;
			flags_s1.temp_ok              <= item.temp_ok;
			current_s1                    <= item.load_current;
		end
		if (advance && s1_valid_s1) begin
			res_event_q    <= ev_next;
			res_load_q     <= state_next.load_flag;
			res_prohibit_q <= (state_next.prohibit_count != '0);
		end
	end

	assign result.valid           = res_valid_q;
	assign result.event_res       = res_event_q;
	assign result.load_present    = res_load_q;
	assign result.prohibit_active = res_prohibit_q;

endmodule

`default_nettype wire
